// ----- hw/rtl/bfs_pkg.sv -----
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared codes for the breadth-first shortest-path block and its checker.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int unsigned VertW = 6;   // vertex id width
  localparam int unsigned NumVW = 7;   // vertex count register width
  localparam int unsigned StatW = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_PATH   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NOPATH = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_INS_WR = 12'b0000_0000_0010,
    S_DEQ    = 12'b0000_0000_0100,
    S_CUR    = 12'b0000_0000_1000,
    S_HEAD   = 12'b0000_0001_0000,
    S_EDGE   = 12'b0000_0010_0000,
    S_WALK   = 12'b0000_0100_0000,
    S_POP    = 12'b0000_1000_0000,
    S_EMIT   = 12'b0001_0000_0000,
    S_LAST   = 12'b0010_0000_0000,
    S_STAT   = 12'b0100_0000_0000,
    S_SPARE  = 12'b1000_0000_0000
  } state_e;

endpackage

// ----- hw/rtl/bfs_shortest_path_top.sv -----
// ----------------------------------------------------------------------------
// bfs_shortest_path_top
// Directed graph store with breadth-first shortest-path queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input words on s_axis carry a command: clear the graph, insert an edge
//   (added at the head of its source's list), or query a path. Results leave
//   on m_axis: vertex id in tdata, status in tuser, tlast on the final word.
//   Clear, insert and every error answer with one status word (tlast high).
//   A path query answers with the vertices from source to destination.
//   cfg_we_i/cfg_wdata_i set the number of vertices in use (0 reads as 1,
//   values above MAX_VERTICES read as MAX_VERTICES); write only while idle.
// Timing:
//   Clear, bad arguments: result word in the next cycle.
//   Insert: one head-memory read, then the write.
//   Path: one sequencer shares the single memory read port of each store;
//   a reached vertex is dequeued and its list head read, then each of its
//   edges is walked; then parents are followed and each output word popped.
//   One word is in flight at a time; s_axis_tready_o drops while it runs.
// Reset clears all lists (one valid bit per list head), the edge count and
//   the vertex count (to MAX_VERTICES). No clearing pass is needed.
// A stalled receiver holds the output register; the sequencer waits on it.
// ----------------------------------------------------------------------------
module bfs_shortest_path_top #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // command[1:0], src_vertex[7:2], dst_vertex[13:8]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // vertex_id[5:0]
  output logic [1:0]  m_axis_tuser_o,   // status[1:0]
  output logic        m_axis_tlast_o,   // last_item
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);
  import bfs_pkg::*;

  localparam int unsigned VIW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam logic [EW-1:0]    EndMark = EW'(MAX_EDGES);
  localparam logic [NumVW-1:0] MaxNv   = NumVW'(MAX_VERTICES);

  // stores
  logic [EW-1:0]       head_mem [MAX_VERTICES];
  logic [EW+VertW-1:0] edge_mem [MAX_EDGES];
  logic [VertW-1:0]    par_mem  [MAX_VERTICES];
  logic [VertW-1:0]    que_mem  [MAX_VERTICES];
  logic [VertW-1:0]    stk_mem  [MAX_VERTICES];

  logic [EW-1:0]       head_rd_q;
  logic [EW+VertW-1:0] edge_rd_q;
  logic [VertW-1:0]    par_rd_q, que_rd_q, stk_rd_q;

  // control
  state_e                 state_q, state_d;
  logic [MAX_VERTICES-1:0] hv_q, hv_d, vis_q, vis_d;
  logic [EW-1:0]          used_q, used_d;
  logic [NumVW-1:0]       nv_q;
  logic [VertW-1:0]       src_q, src_d, dst_q, dst_d, cur_q, cur_d;
  logic [CW-1:0]          qhead_q, qhead_d, qtail_q, qtail_d, depth_q, depth_d;
  logic [StatW-1:0]       stat_q, stat_d;
  logic                   mv_q, mv_d, mlast_q, mlast_d;
  logic [VertW-1:0]       mvid_q, mvid_d;
  logic [StatW-1:0]       mstat_q, mstat_d;

  // memory port controls
  logic             head_re, head_we, edge_re, edge_we, par_re, par_we;
  logic             que_re, que_we, stk_re, stk_we;
  logic [VIW-1:0]   head_ra, head_wa, par_ra, par_wa, que_ra, que_wa, stk_ra, stk_wa;
  logic [EAW-1:0]   edge_ra, edge_wa;
  logic [EW-1:0]    head_wd;
  logic [EW+VertW-1:0] edge_wd;
  logic [VertW-1:0] par_wd, que_wd, stk_wd;

  logic             slot_free, in_acc;
  cmd_e             cmd;
  logic [VertW-1:0] in_src, in_dst, tgt;
  logic [EW-1:0]    e_head, e_link;
  logic [CW-1:0]    depth_m1;

  assign cmd       = cmd_e'(s_axis_tdata_i[1:0]);
  assign in_src    = s_axis_tdata_i[7:2];
  assign in_dst    = s_axis_tdata_i[13:8];
  assign slot_free = !mv_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && slot_free;
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign tgt       = edge_rd_q[VertW-1:0];
  assign e_link    = edge_rd_q[EW+VertW-1:VertW];
  assign e_head    = hv_q[cur_q[VIW-1:0]] ? head_rd_q : EndMark;
  assign depth_m1  = depth_q - CW'(1);

  always_comb begin
    state_d = state_q;
    hv_d    = hv_q;
    vis_d   = vis_q;
    used_d  = used_q;
    src_d   = src_q;
    dst_d   = dst_q;
    cur_d   = cur_q;
    qhead_d = qhead_q;
    qtail_d = qtail_q;
    depth_d = depth_q;
    stat_d  = stat_q;
    mv_d    = mv_q && !m_axis_tready_i;
    mvid_d  = mvid_q;
    mstat_d = mstat_q;
    mlast_d = mlast_q;
    head_re = 1'b0; head_ra = in_src[VIW-1:0];
    head_we = 1'b0; head_wa = src_q[VIW-1:0]; head_wd = used_q;
    edge_re = 1'b0; edge_ra = e_head[EAW-1:0];
    edge_we = 1'b0; edge_wa = used_q[EAW-1:0]; edge_wd = {e_head, dst_q};
    par_re  = 1'b0; par_ra  = dst_q[VIW-1:0];
    par_we  = 1'b0; par_wa  = tgt[VIW-1:0]; par_wd = cur_q;
    que_re  = 1'b0; que_ra  = qhead_q[VIW-1:0];
    que_we  = 1'b0; que_wa  = qtail_q[VIW-1:0]; que_wd = tgt;
    stk_re  = 1'b0; stk_ra  = depth_m1[VIW-1:0];
    stk_we  = 1'b0; stk_wa  = depth_q[VIW-1:0]; stk_wd = par_rd_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          src_d = in_src;
          dst_d = in_dst;
          mvid_d = '0;
          mlast_d = 1'b1;
          case (cmd)
            CMD_CLEAR: begin
              hv_d = '0;
              used_d = '0;
              mv_d = 1'b1;
              mstat_d = ST_OK;
            end
            CMD_INSERT: begin
              if ({1'b0, in_src} >= nv_q || {1'b0, in_dst} >= nv_q) begin
                mv_d = 1'b1;
                mstat_d = ST_RANGE;
              end else if (used_q == EndMark) begin
                mv_d = 1'b1;
                mstat_d = ST_FULL;
              end else begin
                head_re = 1'b1;
                state_d = S_INS_WR;
              end
            end
            CMD_PATH: begin
              if ({1'b0, in_src} >= nv_q || {1'b0, in_dst} >= nv_q) begin
                mv_d = 1'b1;
                mstat_d = ST_RANGE;
              end else if (in_src == in_dst) begin
                mv_d = 1'b1;
                mstat_d = ST_NOPATH;
              end else begin
                vis_d = '0;
                vis_d[in_src[VIW-1:0]] = 1'b1;
                que_we = 1'b1;
                que_wa = '0;
                que_wd = in_src;
                qhead_d = '0;
                qtail_d = CW'(1);
                state_d = S_DEQ;
              end
            end
            default: begin
              mv_d = 1'b1;
              mstat_d = ST_RANGE;
            end
          endcase
        end
      end
      S_INS_WR: begin
        if (slot_free) begin
          cur_d = src_q;
          edge_we = 1'b1;
          edge_wd = {(hv_q[src_q[VIW-1:0]] ? head_rd_q : EndMark), dst_q};
          head_we = 1'b1;
          hv_d[src_q[VIW-1:0]] = 1'b1;
          used_d = used_q + EW'(1);
          mv_d = 1'b1;
          mvid_d = '0;
          mstat_d = ST_OK;
          mlast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DEQ: begin
        if (qhead_q != qtail_q) begin
          que_re = 1'b1;
          qhead_d = qhead_q + CW'(1);
          state_d = S_CUR;
        end else if (vis_q[dst_q[VIW-1:0]]) begin
          par_re = 1'b1;
          depth_d = '0;
          state_d = S_WALK;
        end else begin
          stat_d = ST_NOPATH;
          state_d = S_STAT;
        end
      end
      S_CUR: begin
        cur_d = que_rd_q;
        head_re = 1'b1;
        head_ra = que_rd_q[VIW-1:0];
        state_d = S_HEAD;
      end
      S_HEAD: begin
        if (e_head < used_q) begin
          edge_re = 1'b1;
          state_d = S_EDGE;
        end else begin
          state_d = S_DEQ;
        end
      end
      S_EDGE: begin
        // visit the target if in range and new, then follow the link
        if ({1'b0, tgt} < nv_q && !vis_q[tgt[VIW-1:0]]) begin
          vis_d[tgt[VIW-1:0]] = 1'b1;
          par_we = 1'b1;
          que_we = 1'b1;
          qtail_d = qtail_q + CW'(1);
        end
        if (e_link < used_q) begin
          edge_re = 1'b1;
          edge_ra = e_link[EAW-1:0];
        end else begin
          state_d = S_DEQ;
        end
      end
      S_WALK: begin
        stk_we = 1'b1;
        depth_d = depth_q + CW'(1);
        if (par_rd_q == src_q) begin
          state_d = S_POP;
        end else begin
          par_re = 1'b1;
          par_ra = par_rd_q[VIW-1:0];
        end
      end
      S_POP: begin
        stk_re = 1'b1;
        depth_d = depth_m1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          mv_d = 1'b1;
          mvid_d = stk_rd_q;
          mstat_d = ST_OK;
          mlast_d = 1'b0;
          state_d = (depth_q == '0) ? S_LAST : S_POP;
        end
      end
      S_LAST: begin
        if (slot_free) begin
          mv_d = 1'b1;
          mvid_d = dst_q;
          mstat_d = ST_OK;
          mlast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_STAT: begin
        if (slot_free) begin
          mv_d = 1'b1;
          mvid_d = '0;
          mstat_d = stat_q;
          mlast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hv_q    <= '0;
      vis_q   <= '0;
      used_q  <= '0;
      nv_q    <= MaxNv;
      qhead_q <= '0;
      qtail_q <= '0;
      depth_q <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      hv_q    <= hv_d;
      vis_q   <= vis_d;
      used_q  <= used_d;
      qhead_q <= qhead_d;
      qtail_q <= qtail_d;
      depth_q <= depth_d;
      mv_q    <= mv_d;
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0) begin
          nv_q <= NumVW'(1);
        end else if (cfg_wdata_i > MaxNv) begin
          nv_q <= MaxNv;
        end else begin
          nv_q <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    dst_q   <= dst_d;
    cur_q   <= cur_d;
    stat_q  <= stat_d;
    mvid_q  <= mvid_d;
    mstat_q <= mstat_d;
    mlast_q <= mlast_d;
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (edge_re) edge_rd_q <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    if (par_re) par_rd_q <= par_mem[par_ra];
  end

  always_ff @(posedge clk_i) begin
    if (que_we) que_mem[que_wa] <= que_wd;
    if (que_re) que_rd_q <= que_mem[que_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd_q <= stk_mem[stk_ra];
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = {2'b00, mvid_q};
  assign m_axis_tuser_o  = mstat_q;
  assign m_axis_tlast_o  = mlast_q;

endmodule

// ----- hw/rtl/bfs_checker.sv -----
// ----------------------------------------------------------------------------
// bfs_checker
// Port-level checks for the breadth-first shortest-path block.
// ----------------------------------------------------------------------------
module bfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import bfs_pkg::*;

  // a held output word keeps valid high until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  // an accepted word either answers at once or makes the block busy
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o || !s_axis_tready_o)
    else $error("input accepted without answer or busy");

  // status words are single and carry no vertex
  a_stat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_OK) |->
      m_axis_tlast_o && (m_axis_tdata_o == 8'd0))
    else $error("status word malformed");

  // inner path words are always ok
  a_path_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o == ST_OK)
    else $error("path word with error status");

endmodule

bind bfs_shortest_path_top bfs_checker u_bfs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
